@@ hdl/alpd_pkg.sv @@
package alpd_pkg;

    // field widths
    localparam int XW    = 40;  // coordinates
    localparam int ANGW  = 16;  // heading
    localparam int IDXW  = 16;  // point index
    localparam int PATHW = 48;  // cumulative arc length
    localparam int SKW   = 26;  // distance since last kept point
    localparam int IVW   = 24;  // keep interval register

    localparam logic [IVW-1:0] INTERVAL_RST = IVW'(2000);

    // default clamp on each coordinate delta: +-(2^n - 1)
    localparam int DELTA_LIMIT_BITS = 24;

endpackage

@@ hdl/arc_length_point_decimator.sv @@
// Channel   | Direction | Valid    | Ready    | Payload
// ----------+-----------+----------+----------+---------------------------------------------
// point in  | input     | i_valid  | o_ready  | i_x_mm i_y_mm i_heading_cdeg i_point_index
//           |           |          |          | i_last_point
// kept out  | output    | o_valid  | i_ready  | o_kept_x_mm o_kept_y_mm o_kept_heading_cdeg
//           |           |          |          | o_kept_index o_arc_length_mm o_is_final
// config    | input     | i_cfg_we | -        | i_cfg_data (keep interval, mm)
//
// Flow: one point at a time, taken in only when idle. Steps: clamped deltas, bit-serial
//   squaring, restoring square root (D + 1 root bits, D = DELTA_LIMIT_BITS, 24 at the
//   default), decide, idle. The first point of a line skips squaring and square root.
// Reset: synchronous, active low; clears the line state and sets the interval to 2000 mm.
// Stalls: a kept point sits in the output register while the next point is taken in and
//   worked on; only the decide step of a kept point waits, if the output is still full.

module arc_length_point_decimator #(
    parameter int DELTA_LIMIT_BITS = alpd_pkg::DELTA_LIMIT_BITS  // 8..30
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,

    input  logic                        i_cfg_we,
    input  logic [alpd_pkg::IVW-1:0]    i_cfg_data,

    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic signed [alpd_pkg::XW-1:0]   i_x_mm,
    input  logic signed [alpd_pkg::XW-1:0]   i_y_mm,
    input  logic [alpd_pkg::ANGW-1:0]   i_heading_cdeg,
    input  logic [alpd_pkg::IDXW-1:0]   i_point_index,
    input  logic                        i_last_point,

    output logic                        o_valid,
    input  logic                        i_ready,
    output logic signed [alpd_pkg::XW-1:0]   o_kept_x_mm,
    output logic signed [alpd_pkg::XW-1:0]   o_kept_y_mm,
    output logic [alpd_pkg::ANGW-1:0]   o_kept_heading_cdeg,
    output logic [alpd_pkg::IDXW-1:0]   o_kept_index,
    output logic [alpd_pkg::PATHW-1:0]  o_arc_length_mm,
    output logic                        o_is_final
);

    localparam int D      = DELTA_LIMIT_BITS;
    localparam int XW     = alpd_pkg::XW;
    localparam int SKW    = alpd_pkg::SKW;
    localparam int PATHW  = alpd_pkg::PATHW;
    localparam int SUMW   = 2 * D + 2;           // dx^2 + dy^2 < 2^(2D+1)
    localparam int RW     = D + 1;               // root bits
    localparam int RMW    = RW + 2;              // root remainder
    localparam int SKSUMW = ((SKW > RW) ? SKW : RW) + 1;
    localparam int CNTW   = $clog2(D + 2);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_DELTA = 5'b00010,
        S_SQR   = 5'b00100,
        S_ROOT  = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state r_state, n_state;

    // config
    logic [alpd_pkg::IVW-1:0] r_interval;

    // line state
    logic [XW-1:0]     r_prev_x, r_prev_y;
    logic [PATHW-1:0]  r_path;
    logic [SKW-1:0]    r_since;
    logic              r_have_prev;

    // current point
    logic [XW-1:0]     r_cur_x, r_cur_y;
    logic [alpd_pkg::ANGW-1:0] r_cur_hdg;
    logic [alpd_pkg::IDXW-1:0] r_cur_idx;
    logic              r_last;

    // serial datapath
    logic [2*D-1:0]    r_mcand_x, r_mcand_y;
    logic [D-1:0]      r_mplier_x, r_mplier_y;
    logic [SUMW-1:0]   r_acc;        // sum of squares, then shifted out 2 bits a cycle
    logic [RMW-1:0]    r_rem;
    logic [RW-1:0]     r_root;
    logic [CNTW-1:0]   r_cnt;

    logic              r_o_valid;

    // |a - b| clamped to 2^D - 1
    function automatic logic [D-1:0] f_clamp_delta(input logic [XW-1:0] a,
                                                   input logic [XW-1:0] b);
        logic [XW:0] diff;
        logic [XW:0] mag;
        diff = {a[XW-1], a} - {b[XW-1], b};
        mag  = diff[XW] ? (~diff + 1'b1) : diff;
        if (|mag[XW:D]) begin
            return {D{1'b1}};
        end
        return mag[D-1:0];
    endfunction

    logic [D-1:0]       w_ax, w_ay;
    logic [SUMW-1:0]    w_acc_next;
    logic [RMW+1:0]     w_rem_sh;
    logic [RMW+1:0]     w_trial;
    logic               w_bit;
    logic [PATHW:0]     w_path_sum;
    logic [PATHW-1:0]   w_path_sat;
    logic [SKSUMW-1:0]  w_since_sum;
    logic [SKW-1:0]     w_since_sat;
    logic               w_first, w_emit, w_out_free, w_go, w_in_xfer;

    assign o_ready   = (r_state == S_IDLE);
    assign o_valid   = r_o_valid;
    assign w_in_xfer = i_valid & o_ready;

    assign w_ax = f_clamp_delta(r_cur_x, r_prev_x);
    assign w_ay = f_clamp_delta(r_cur_y, r_prev_y);

    // one shift-add step of both squares
    assign w_acc_next = r_acc
                      + (r_mplier_x[0] ? SUMW'(r_mcand_x) : '0)
                      + (r_mplier_y[0] ? SUMW'(r_mcand_y) : '0);

    // one restoring square-root step
    assign w_rem_sh = {r_rem, r_acc[SUMW-1 -: 2]};
    assign w_trial  = (RMW+2)'({r_root, 2'b01});
    assign w_bit    = (w_rem_sh >= w_trial);

    // accumulate step length and decide
    assign w_path_sum  = {1'b0, r_path} + (PATHW+1)'(r_root);
    assign w_path_sat  = w_path_sum[PATHW] ? {PATHW{1'b1}} : w_path_sum[PATHW-1:0];
    assign w_since_sum = SKSUMW'(r_since) + SKSUMW'(r_root);
    assign w_since_sat = (|w_since_sum[SKSUMW-1:SKW]) ? {SKW{1'b1}} : w_since_sum[SKW-1:0];

    assign w_first    = ~r_have_prev;
    assign w_emit     = w_first | r_last | (w_since_sat >= SKW'(r_interval));
    assign w_out_free = ~r_o_valid | i_ready;
    assign w_go       = (r_state == S_DONE) & (~w_emit | w_out_free);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (w_in_xfer) n_state = S_DELTA;
            S_DELTA: n_state = r_have_prev ? S_SQR : S_DONE;
            S_SQR:   if (r_cnt == CNTW'(D - 1)) n_state = S_ROOT;
            S_ROOT:  if (r_cnt == CNTW'(RW - 1)) n_state = S_DONE;
            S_DONE:  if (w_go) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_interval  <= alpd_pkg::INTERVAL_RST;
            r_prev_x    <= '0;
            r_prev_y    <= '0;
            r_path      <= '0;
            r_since     <= '0;
            r_have_prev <= 1'b0;
            r_o_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_interval <= i_cfg_data;
            end
            if (w_go) begin
                r_prev_x    <= r_cur_x;
                r_prev_y    <= r_cur_y;
                r_have_prev <= ~r_last;
                r_path      <= w_first ? '0 : w_path_sat;
                r_since     <= w_emit ? '0 : w_since_sat;
            end
            if (w_go && w_emit) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // datapath, no reset
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_cur_x   <= i_x_mm;
            r_cur_y   <= i_y_mm;
            r_cur_hdg <= i_heading_cdeg;
            r_cur_idx <= i_point_index;
            r_last    <= i_last_point;
        end
        unique case (r_state)
            S_DELTA: begin
                r_mcand_x  <= (2*D)'(w_ax);
                r_mcand_y  <= (2*D)'(w_ay);
                r_mplier_x <= w_ax;
                r_mplier_y <= w_ay;
                r_acc      <= '0;
                r_rem      <= '0;
                r_root     <= '0;
                r_cnt      <= '0;
            end
            S_SQR: begin
                r_acc      <= w_acc_next;
                r_mcand_x  <= r_mcand_x << 1;
                r_mcand_y  <= r_mcand_y << 1;
                r_mplier_x <= r_mplier_x >> 1;
                r_mplier_y <= r_mplier_y >> 1;
                r_cnt      <= (r_cnt == CNTW'(D - 1)) ? '0 : r_cnt + 1'b1;
            end
            S_ROOT: begin
                r_acc  <= r_acc << 2;
                r_rem  <= w_bit ? RMW'(w_rem_sh - w_trial) : RMW'(w_rem_sh);
                r_root <= {r_root[RW-2:0], w_bit};
                r_cnt  <= r_cnt + 1'b1;
            end
            default: begin
            end
        endcase
        if (w_go && w_emit) begin
            o_kept_x_mm         <= r_cur_x;
            o_kept_y_mm         <= r_cur_y;
            o_kept_heading_cdeg <= r_cur_hdg;
            o_kept_index        <= r_cur_idx;
            o_arc_length_mm     <= w_first ? '0 : w_path_sat;
            o_is_final          <= r_last;
        end
    end

    // remainder of the root never exceeds twice the partial root
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROOT) |-> (r_rem <= RMW'({r_root, 1'b0})))
        else $error("sqrt remainder out of bound");

    // a new kept point is loaded only from the decide step
    a_load_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && !$past(r_o_valid)) |-> $past(r_state == S_DONE))
        else $error("output loaded outside decide step");

    // a final point closes the line
    a_final_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_go && r_last) |=> !r_have_prev)
        else $error("line not closed after final point");

    // the first point of a line carries zero arc length
    a_first_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_go && w_first) |=> (o_arc_length_mm == '0) && o_valid)
        else $error("first point arc length not zero");

endmodule
